@@ rtl/magnetometer_hard_iron_calibrator_unit_macros.svh @@
// Assertion macros shared by the calibrator RTL.
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATOR_UNIT_MACROS_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATOR_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MHIC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define MHIC_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/mhic_pkg.sv @@
package mhic_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam logic [31:0] UPDATE_PERIOD_RESET = 32'd101500;
   localparam logic [31:0] CAL_WINDOW_RESET = 32'd30000000;
   localparam int SCALE_UNITY = 10;
   localparam int SCALE_MAX = 32767;
   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_UPDATE_PERIOD  = 2'd0,
      REG_CAL_WINDOW     = 2'd1,
      REG_CORRECT_ENABLE = 2'd2
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SUM,
      ST_SCALE_GO,
      ST_SCALE_WAIT,
      ST_MULT,
      ST_CORR_GO,
      ST_CORR_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic seed;
      logic track;
      logic finish;
      logic scale_go;
      logic mult_go;
      logic corr_go;
   } lane_ctl_type;

   typedef struct packed {
      logic div_done;
   } lane_sts_type;

endpackage

@@ rtl/mhic_div.sv @@
module mhic_div import mhic_pkg::*; #(
   parameter int NW = 32,
   parameter int DW = 21
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_sh;
   logic          take;

   assign rem_sh = {rem_ff[DW-1:0], q_ff[NW-1]};
   assign take   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = take ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         q_in    = {q_ff[NW-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ rtl/mhic_lane.sv @@
module mhic_lane import mhic_pkg::*; #(
   parameter int W = SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  logic [W-1:0] sample_in,
   input  logic [W+8:0] num_in,
   output logic [W+2:0] half_out,
   output logic [W-1:0] raw_out,
   output logic [W-1:0] corr_out,
   output lane_sts_type sts
);

   localparam int NW = W + 16;
   localparam int DW = W + 5;
   localparam int CH = (NW + 15) / 16;
   localparam int XW = CH * 16;
   localparam int AW = XW + NW;
   localparam int RCW = $clog2(CH + 1);
   localparam logic [NW-1:0] RECIP10 = NW'(((64'd1 << (NW + 3)) / 64'd10) + 64'd1);
   localparam logic [NW-1:0] POS_LIM = NW'((1 << (W - 1)) - 1);
   localparam logic [NW-1:0] NEG_LIM = NW'(1 << (W - 1));
   localparam logic [NW-1:0] SCALE_LIM = NW'(SCALE_MAX);

   logic signed [W-1:0] s_ff, s_in;
   logic signed [W-1:0] min_ff, min_in;
   logic signed [W-1:0] max_ff, max_in;
   logic signed [W-1:0] off_ff, off_in;
   logic signed [15:0]  scale_ff, scale_in;
   logic [W+2:0]        half_ff, half_in;
   logic [DW-1:0]       den3_ff, den3_in;
   logic [NW-1:0]       mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [W-1:0]        corr_ff, corr_in;
   logic [XW-1:0]       xr_ff, xr_in;
   logic [AW-1:0]       acc_ff, acc_in;
   logic [RCW-1:0]      rcnt_ff, rcnt_in;
   logic                rdone_ff, rdone_in;

   logic signed [W:0]    sum_mm;
   logic signed [W:0]    off_w;
   logic [W:0]           diff_mm;
   logic signed [W:0]    v;
   logic signed [W+16:0] prod;
   logic [W+16:0]        prod_mag;
   logic                 div_start;
   logic [NW-1:0]        div_num;
   logic [DW-1:0]        div_den;
   logic                 div_done;
   logic [NW-1:0]        quot;
   logic [NW+15:0]       part;
   logic [NW-1:0]        quot10;

   assign sum_mm   = $signed({min_ff[W-1], min_ff}) + $signed({max_ff[W-1], max_ff});
   assign off_w    = (sum_mm + $signed((W+1)'(sum_mm[W]))) >>> 1;
   assign diff_mm  = $unsigned($signed({max_ff[W-1], max_ff}) - $signed({min_ff[W-1], min_ff}));
   assign v        = $signed({s_ff[W-1], s_ff}) - $signed({off_ff[W-1], off_ff});
   assign prod     = v * scale_ff;
   assign prod_mag = prod[W+16] ? $unsigned(-prod) : $unsigned(prod);

   assign div_start = ctl.scale_go;
   assign div_num   = NW'(num_in);
   assign div_den   = den3_ff;

   assign part   = (NW+16)'(xr_ff[XW-1 -: 16]) * (NW+16)'(RECIP10);
   assign quot10 = {3'b000, acc_ff[2*NW-1:NW+3]};

   mhic_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   // The divide by ten multiplies by a rounded-up reciprocal, 16 bits of the
   // magnitude per cycle, most significant part first.
   always_comb begin
      xr_in    = xr_ff;
      acc_in   = acc_ff;
      rcnt_in  = rcnt_ff;
      rdone_in = 1'b0;
      if (ctl.corr_go) begin
         xr_in   = XW'(mag_ff);
         acc_in  = '0;
         rcnt_in = RCW'(CH);
      end else if (rcnt_ff != '0) begin
         acc_in   = (acc_ff << 16) + AW'(part);
         xr_in    = xr_ff << 16;
         rcnt_in  = rcnt_ff - 1'b1;
         rdone_in = (rcnt_ff == RCW'(1));
      end
   end

   always_comb begin
      s_in     = s_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      off_in   = off_ff;
      scale_in = scale_ff;
      half_in  = half_ff;
      den3_in  = den3_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      corr_in  = corr_ff;
      if (ctl.load) begin
         s_in = $signed(sample_in);
      end
      if (ctl.seed) begin
         min_in = $signed(sample_in);
         max_in = $signed(sample_in);
         off_in = '0;
      end
      if (ctl.track) begin
         if (s_ff < min_ff) begin
            min_in = s_ff;
         end
         if (s_ff > max_ff) begin
            max_in = s_ff;
         end
      end
      if (ctl.finish) begin
         off_in  = off_w[W-1:0];
         half_in = (W+3)'(diff_mm) * (W+3)'(5);
         den3_in = DW'(diff_mm) * DW'(15);
      end
      if (ctl.mult_go) begin
         mag_in = prod_mag[NW-1:0];
         neg_in = prod[W+16];
      end
      if (div_done) begin
         if (half_ff == '0) begin
            scale_in = 16'(SCALE_UNITY);
         end else if (quot > SCALE_LIM) begin
            scale_in = 16'(SCALE_MAX);
         end else begin
            scale_in = $signed(quot[15:0]);
         end
      end
      if (rdone_ff) begin
         if (!neg_ff) begin
            corr_in = (quot10 > POS_LIM) ? POS_LIM[W-1:0] : quot10[W-1:0];
         end else begin
            corr_in = (quot10 > NEG_LIM) ? NEG_LIM[W-1:0] : (~quot10[W-1:0] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      min_ff  <= min_in;
      max_ff  <= max_in;
      half_ff <= half_in;
      den3_ff <= den3_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      corr_ff <= corr_in;
      xr_ff   <= xr_in;
      acc_ff  <= acc_in;
      if (reset) begin
         off_ff   <= '0;
         scale_ff <= 16'(SCALE_UNITY);
         rcnt_ff  <= '0;
         rdone_ff <= 1'b0;
      end else begin
         off_ff   <= off_in;
         scale_ff <= scale_in;
         rcnt_ff  <= rcnt_in;
         rdone_ff <= rdone_in;
      end
   end

   assign half_out     = half_ff;
   assign raw_out      = s_ff;
   assign corr_out     = corr_ff;
   assign sts.div_done = div_done | rdone_ff;

endmodule

@@ rtl/magnetometer_hard_iron_calibrator_unit.sv @@
// Hard-iron magnetometer calibrator. One sample word is taken at a time; a word whose
// timestamp comes before the next due time is dropped without a response. An accepted
// word passes the update, multiply and correction states before its response word is
// registered, and the next word can enter once that response is loaded. The word that
// closes the calibration window also passes the sum and scale states, because each of
// the three axis lanes then runs a bit-serial divider of SAMPLE_BITS+16 steps for the
// scale. The divide by ten of the correction is a reciprocal multiply that takes 16 bits
// of the product per cycle. The response register lets a new word enter while a finished
// response waits; the word after that stalls until the response is taken.
`include "magnetometer_hard_iron_calibrator_unit_macros.svh"

module magnetometer_hard_iron_calibrator_unit import mhic_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // sample_x, sample_y, sample_z, time_us, zero fill
   input  logic [((3*SAMPLE_BITS+32+7)/8)*8-1:0] req_tdata,
   // start_cal
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, out_z, zero fill
   output logic [((3*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // calibrating, cal_finished
   output logic [1:0] rsp_tuser,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   localparam int W = SAMPLE_BITS;
   localparam int RSP_W = ((3*SAMPLE_BITS+7)/8)*8;

   state_type state_ff, state_in;

   logic [31:0] period_ff, period_in;
   logic [31:0] window_ff, window_in;
   logic        enable_ff, enable_in;
   logic [31:0] due_ff, due_in;
   logic [31:0] wstart_ff, wstart_in;
   logic        active_ff, active_in;
   logic        finished_ff, finished_in;
   logic [W+8:0] num_ff, num_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3*W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   lane_ctl_type ctl;
   lane_sts_type sts [3];
   logic [W+2:0] half [3];
   logic [W-1:0] raw [3];
   logic [W-1:0] corr [3];
   logic [W-1:0] res [3];

   logic [31:0] now;
   logic [31:0] gap;
   logic        pass;
   logic        accept;
   logic        start;
   logic        win_open;
   logic        closing;
   logic        all_done;
   logic        out_free;
   logic        csr_wr;
   logic [W+4:0] hsum;

   assign now      = req_tdata[3*W+31:3*W];
   assign start    = req_tuser[0];
   assign gap      = now - due_ff;
   assign pass     = !gap[31];
   assign accept   = req_tvalid && req_tready;
   assign win_open = (due_ff - wstart_ff) < window_ff;
   assign closing  = active_ff && !win_open;
   assign all_done = sts[0].div_done && sts[1].div_done && sts[2].div_done;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign hsum     = (W+5)'(half[0]) + (W+5)'(half[1]) + (W+5)'(half[2]);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : gen_lane
         mhic_lane #(.W(W)) u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .sample_in (req_tdata[g*W +: W]),
            .num_in    (num_ff),
            .half_out  (half[g]),
            .raw_out   (raw[g]),
            .corr_out  (corr[g]),
            .sts       (sts[g])
         );
         assign res[g] = enable_ff ? corr[g] : raw[g];
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && pass) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:     state_in = closing ? ST_SUM : ST_MULT;
         ST_SUM:        state_in = ST_SCALE_GO;
         ST_SCALE_GO:   state_in = ST_SCALE_WAIT;
         ST_SCALE_WAIT: state_in = all_done ? ST_MULT : ST_SCALE_WAIT;
         ST_MULT:       state_in = ST_CORR_GO;
         ST_CORR_GO:    state_in = ST_CORR_WAIT;
         ST_CORR_WAIT:  state_in = all_done ? ST_DONE : ST_CORR_WAIT;
         ST_DONE:       state_in = out_free ? ST_IDLE : ST_DONE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl         = '0;
      req_tready  = 1'b0;
      due_in      = due_ff;
      wstart_in   = wstart_ff;
      active_in   = active_ff;
      finished_in = finished_ff;
      num_in      = num_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && pass) begin
               ctl.load    = 1'b1;
               ctl.seed    = start;
               due_in      = now + period_ff;
               finished_in = 1'b0;
               if (start) begin
                  wstart_in = now + period_ff;
                  active_in = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            ctl.track  = active_ff && win_open;
            ctl.finish = closing;
            if (closing) begin
               active_in   = 1'b0;
               finished_in = 1'b1;
            end
         end
         ST_SUM:      num_in = (W+9)'(hsum) * (W+9)'(SCALE_UNITY);
         ST_SCALE_GO: ctl.scale_go = 1'b1;
         ST_MULT:     ctl.mult_go = 1'b1;
         ST_CORR_GO:  ctl.corr_go = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {res[2], res[1], res[0]};
         rsp_user_in  = {finished_ff, active_ff};
      end
   end

   always_comb begin
      period_in = period_ff;
      window_in = window_ff;
      enable_in = enable_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_UPDATE_PERIOD:  period_in = csr_pwdata;
            REG_CAL_WINDOW:     window_in = csr_pwdata;
            REG_CORRECT_ENABLE: enable_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_UPDATE_PERIOD:  csr_prdata = period_ff;
         REG_CAL_WINDOW:     csr_prdata = window_ff;
         REG_CORRECT_ENABLE: csr_prdata = {31'd0, enable_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= UPDATE_PERIOD_RESET;
         window_ff    <= CAL_WINDOW_RESET;
         enable_ff    <= 1'b0;
         due_ff       <= '0;
         wstart_ff    <= '0;
         active_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         window_ff    <= window_in;
         enable_ff    <= enable_in;
         due_ff       <= due_in;
         wstart_ff    <= wstart_in;
         active_ff    <= active_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_user_ff;

   `MHIC_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE, "response without finished item")
   `MHIC_NEVER(a_fin_and_active, finished_ff && active_ff, "window both open and finished")
   `MHIC_ASSERT(a_div_done_state, all_done |-> (state_ff == ST_SCALE_WAIT || state_ff == ST_CORR_WAIT), "divider finished outside a wait state")
   `MHIC_ASSERT(a_lanes_lockstep, sts[0].div_done |-> (sts[1].div_done && sts[2].div_done), "axis lanes out of step")

endmodule
